>>> design/akb_pkg.sv
package akb_pkg;

  localparam int N_MAX = 8;
  localparam int K_MAX = 7;
  localparam int IW    = 3;
  localparam int AW    = 2 * IW;

  typedef enum logic [2:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_RUN    = 3'd2,
    CMD_READ_H = 3'd3,
    CMD_READ_Q = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_SIZE  = 2'd0,
    CFG_STEPS = 2'd1,
    CFG_TOL   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RS_DONE  = 2'd0,
    RS_EARLY = 2'd1,
    RS_ZERO  = 2'd2,
    RS_READ  = 2'd3
  } run_status_e;

  typedef enum logic [2:0] {
    MS_BB,
    MS_WW,
    MS_AQ,
    MS_QW,
    MS_HQ
  } mul_sel_e;

  typedef enum logic [2:0] {
    PH_NB,
    PH_QB,
    PH_MV,
    PH_DOT,
    PH_UPD,
    PH_NW,
    PH_QW
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_MEM,
    ST_RD_OUT,
    ST_M_RD,
    ST_M_MUL,
    ST_M_ACC,
    ST_M_END,
    ST_SQ_WAIT,
    ST_D_GO,
    ST_D_WAIT
  } state_e;

  typedef struct packed {
    logic          a_we;
    logic          b_we;
    logic [AW-1:0] a_waddr;
    logic [IW-1:0] b_widx;
    logic [AW-1:0] a_raddr;
    logic [AW-1:0] q_raddr;
    logic [AW-1:0] h_raddr;
    logic          q_we;
    logic [AW-1:0] q_waddr;
    logic          h_we;
    logic [AW-1:0] h_waddr;
    logic          h_wsel;
    logic          vld_clr;
    logic          mul_go;
    mul_sel_e      mul_sel;
    logic [IW-1:0] vidx;
    logic [IW-1:0] widx;
    logic          acc_go;
    logic          acc_first;
    logic          acc_exact;
    logic          upd_go;
    logic          w_ld;
    logic          hij_ld;
    logic          sqrt_go;
    logic          div_go;
    logic          div_from_w;
    logic          out_run;
    logic          out_read;
    logic          rd_is_h;
    logic          rd_ok;
    run_status_e   status;
    logic [2:0]    steps;
  } dp_cmd_t;

  typedef struct packed {
    logic        out_busy;
    logic        sqrt_done;
    logic        div_done;
    logic [30:0] nrm;
  } dp_stat_t;

endpackage

>>> design/akb_isqrt.sv
module akb_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] radicand_i,
  output logic        done_o,
  output logic [30:0] root_o
);
  localparam int SqSteps = 31;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [34:0] rem_q, rem_n, trial;
  logic [30:0] root_q;
  logic [61:0] xs_q;
  logic        ge;

  assign rem_n = {rem_q[32:0], xs_q[61:60]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_n >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(SqSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      root_q <= '0;
      xs_q   <= radicand_i;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_n - trial : rem_n;
      root_q <= {root_q[29:0], ge};
      xs_q   <= {xs_q[59:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

>>> design/akb_div.sv
module akb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               neg_i,
  input  logic [31:0]        mag_i,
  input  logic [30:0]        divisor_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  localparam int DivSteps = 48;

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [30:0] rem_q, dvs_q;
  logic [47:0] num_q, quo_q;
  logic [31:0] rn;
  logic        ge;

  assign rn = {rem_q, num_q[47]};
  assign ge = rn >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag_i, 16'h0000} + {18'd0, divisor_i[30:1]};
      dvs_q <= divisor_i;
      neg_q <= neg_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 31'(rn - {1'b0, dvs_q}) : rn[30:0];
      quo_q <= {quo_q[46:0], ge};
      num_q <= {num_q[46:0], 1'b0};
    end
  end

  always_comb begin
    if (!neg_q) begin
      quot_o = (|quo_q[47:31]) ? 32'sh7fffffff : $signed({1'b0, quo_q[30:0]});
    end else begin
      if ((|quo_q[47:32]) || (quo_q[31] && (|quo_q[30:0]))) begin
        quot_o = 32'sh80000000;
      end else begin
        quot_o = $signed(32'(-quo_q[31:0]));
      end
    end
  end

  assign done_o = done_q;
endmodule

>>> design/akb_dp.sv
module akb_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  akb_pkg::dp_cmd_t    cmd_i,
  input  logic signed [31:0]  elem_value_i,
  input  logic                out_ready_i,
  output akb_pkg::dp_stat_t   stat_o,
  output logic                out_valid_o,
  output logic signed [31:0]  read_value_o,
  output logic [1:0]          run_status_o,
  output logic [2:0]          steps_done_o
);
  import akb_pkg::*;

  localparam int Depth = N_MAX * N_MAX;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
    if ((&x[66:31]) || !(|x[66:31])) begin
      return x[31:0];
    end else begin
      return x[66] ? 32'sh80000000 : 32'sh7fffffff;
    end
  endfunction

  logic signed [31:0] a_mem [Depth];
  logic signed [31:0] q_mem [Depth];
  logic signed [31:0] h_mem [Depth];
  logic [Depth-1:0]   q_vld_q, h_vld_q;
  logic signed [31:0] b_vec [N_MAX];
  logic signed [31:0] w_vec [N_MAX];
  logic signed [31:0] hij_q, a_rd_q, q_rd_q, h_rd_q, q_val;
  logic               q_rv_q, h_rv_q;
  logic signed [63:0] prod_q, prod_d, rnd;
  logic signed [66:0] acc_q, term, upd;
  logic signed [31:0] opa, opb, num, div_res, h_wdata;
  logic               big_q, sq_done, div_done;
  logic [30:0]        sq_root, nrm;
  logic               out_valid_q;
  logic signed [31:0] out_value_q, rd_sel;
  logic [1:0]         out_status_q;
  logic [2:0]         out_steps_q;

  assign q_val = q_rv_q ? q_rd_q : 32'sd0;

  always_comb begin
    case (cmd_i.mul_sel)
      MS_BB: begin
        opa = b_vec[cmd_i.vidx];
        opb = b_vec[cmd_i.vidx];
      end
      MS_WW: begin
        opa = w_vec[cmd_i.vidx];
        opb = w_vec[cmd_i.vidx];
      end
      MS_AQ: begin
        opa = a_rd_q;
        opb = q_val;
      end
      MS_QW: begin
        opa = q_val;
        opb = w_vec[cmd_i.vidx];
      end
      MS_HQ: begin
        opa = hij_q;
        opb = q_val;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_d = opa * opb;
  assign rnd    = (prod_q + 64'sd32768) >>> 16;
  assign term   = cmd_i.acc_exact ? {{3{prod_q[63]}}, prod_q} : {{3{rnd[63]}}, rnd};
  assign upd    = {{35{w_vec[cmd_i.vidx][31]}}, w_vec[cmd_i.vidx]} - {{3{rnd[63]}}, rnd};
  assign nrm    = big_q ? 31'h7fffffff : sq_root;
  assign num    = cmd_i.div_from_w ? w_vec[cmd_i.vidx] : b_vec[cmd_i.vidx];
  assign h_wdata = cmd_i.h_wsel ? $signed({1'b0, nrm}) : sat32(acc_q);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) prod_q <= prod_d;
    if (cmd_i.acc_go) acc_q <= cmd_i.acc_first ? term : acc_q + term;
    if (cmd_i.sqrt_go) big_q <= |acc_q[66:62];
    if (cmd_i.hij_ld) hij_q <= sat32(acc_q);
    if (cmd_i.w_ld) w_vec[cmd_i.widx] <= sat32(acc_q);
    if (cmd_i.upd_go) w_vec[cmd_i.vidx] <= sat32(upd);
    if (cmd_i.b_we) b_vec[cmd_i.b_widx] <= elem_value_i;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.a_we) a_mem[cmd_i.a_waddr] <= elem_value_i;
    a_rd_q <= a_mem[cmd_i.a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_we) q_mem[cmd_i.q_waddr] <= div_res;
    q_rd_q <= q_mem[cmd_i.q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.h_we) h_mem[cmd_i.h_waddr] <= h_wdata;
    h_rd_q <= h_mem[cmd_i.h_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= '0;
      h_vld_q <= '0;
      q_rv_q  <= 1'b0;
      h_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.vld_clr) begin
        q_vld_q <= '0;
        h_vld_q <= '0;
      end else begin
        if (cmd_i.q_we) q_vld_q[cmd_i.q_waddr] <= 1'b1;
        if (cmd_i.h_we) h_vld_q[cmd_i.h_waddr] <= 1'b1;
      end
      q_rv_q <= q_vld_q[cmd_i.q_raddr];
      h_rv_q <= h_vld_q[cmd_i.h_raddr];
    end
  end

  akb_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_go),
    .radicand_i (acc_q[61:0]),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  akb_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_go),
    .neg_i     (num[31]),
    .mag_i     (num[31] ? 32'(-num) : 32'(num)),
    .divisor_i (nrm),
    .done_o    (div_done),
    .quot_o    (div_res)
  );

  // result register
  always_comb begin
    if (cmd_i.rd_is_h) begin
      rd_sel = (cmd_i.rd_ok && h_rv_q) ? h_rd_q : 32'sd0;
    end else begin
      rd_sel = q_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_run || cmd_i.out_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_run || cmd_i.out_read) begin
      out_value_q  <= cmd_i.out_run ? 32'sd0 : rd_sel;
      out_status_q <= cmd_i.status;
      out_steps_q  <= cmd_i.steps;
    end
  end

  assign stat_o.out_busy  = out_valid_q;
  assign stat_o.sqrt_done = sq_done;
  assign stat_o.div_done  = div_done;
  assign stat_o.nrm       = nrm;

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign run_status_o = out_status_q;
  assign steps_done_o = out_steps_q;
endmodule

>>> design/akb_ctrl.sv
module akb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output logic              cfg_ready_o,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        in_cmd_i,
  input  logic [2:0]        in_row_i,
  input  logic [2:0]        in_col_i,
  input  akb_pkg::dp_stat_t stat_i,
  output akb_pkg::dp_cmd_t  cmd_o
);
  import akb_pkg::*;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  size_q, n_q, n_d, i_q, i_d, p_q, p_d, i_nx, p_nx, n_cl;
  logic [2:0]  step_q, k_q, k_d, j_q, j_d, j_nx, last_q, last_d;
  logic [30:0] tol_q;
  logic [2:0]  row_q, row_d, col_q, col_d;
  logic        rdh_q, rdh_d;
  logic [IW-1:0] iix, pix;

  assign cfg_ready_o = 1'b1;
  assign i_nx = i_q + 4'd1;
  assign p_nx = p_q + 4'd1;
  assign j_nx = j_q + 3'd1;
  assign iix  = i_q[IW-1:0];
  assign pix  = p_q[IW-1:0];

  always_comb begin
    if (size_q == 4'd0) n_cl = 4'd1;
    else if (size_q > 4'(N_MAX)) n_cl = 4'(N_MAX);
    else n_cl = size_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'(N_MAX);
      step_q <= 3'(K_MAX);
      tol_q  <= 31'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SIZE:  size_q <= cfg_data_i[3:0];
        CFG_STEPS: step_q <= cfg_data_i[2:0];
        CFG_TOL:   tol_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_NB;
      n_q     <= 4'd1;
      k_q     <= '0;
      i_q     <= '0;
      p_q     <= '0;
      j_q     <= '0;
      last_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      rdh_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      n_q     <= n_d;
      k_q     <= k_d;
      i_q     <= i_d;
      p_q     <= p_d;
      j_q     <= j_d;
      last_q  <= last_d;
      row_q   <= row_d;
      col_q   <= col_d;
      rdh_q   <= rdh_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    n_d        = n_q;
    k_d        = k_q;
    i_d        = i_q;
    p_d        = p_q;
    j_d        = j_q;
    last_d     = last_q;
    row_d      = row_q;
    col_d      = col_q;
    rdh_d      = rdh_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;

    cmd_o.a_waddr = {in_row_i, in_col_i};
    cmd_o.b_widx  = in_row_i;
    cmd_o.a_raddr = {iix, pix};
    cmd_o.q_raddr = (phase_q == PH_MV) ? {pix, j_q} : {pix, iix};
    cmd_o.h_raddr = {row_q, col_q};
    cmd_o.vidx    = pix;
    cmd_o.widx    = iix;
    cmd_o.q_waddr = {iix, (phase_q == PH_QB) ? 3'd0 : j_nx};
    cmd_o.h_waddr = {iix, j_q};
    cmd_o.steps   = last_q;
    cmd_o.status  = RS_DONE;
    case (phase_q)
      PH_NB:   cmd_o.mul_sel = MS_BB;
      PH_NW:   cmd_o.mul_sel = MS_WW;
      PH_MV:   cmd_o.mul_sel = MS_AQ;
      PH_DOT:  cmd_o.mul_sel = MS_QW;
      PH_UPD:  cmd_o.mul_sel = MS_HQ;
      default: cmd_o.mul_sel = MS_BB;
    endcase

    case (state_q)
      ST_IDLE: begin
        in_ready_o = !stat_i.out_busy;
        if (in_valid_i && !stat_i.out_busy) begin
          case (in_cmd_i)
            CMD_LOAD_A: cmd_o.a_we = 1'b1;
            CMD_LOAD_B: cmd_o.b_we = 1'b1;
            CMD_RUN: begin
              n_d = n_cl;
              k_d = ({1'b0, step_q} > n_cl - 4'd1) ? 3'(n_cl - 4'd1) : step_q;
              cmd_o.vld_clr = 1'b1;
              phase_d = PH_NB;
              p_d     = '0;
              state_d = ST_M_RD;
            end
            CMD_READ_H, CMD_READ_Q: begin
              row_d   = in_row_i;
              col_d   = in_col_i;
              rdh_d   = (in_cmd_i == CMD_READ_H);
              state_d = ST_RD_MEM;
            end
            default: ;
          endcase
        end
      end
      ST_RD_MEM: begin
        cmd_o.q_raddr = {row_q, col_q};
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        cmd_o.out_read = 1'b1;
        cmd_o.rd_is_h  = rdh_q;
        cmd_o.rd_ok    = (col_q != 3'(K_MAX));
        cmd_o.status   = RS_READ;
        state_d = ST_IDLE;
      end
      ST_M_RD: state_d = ST_M_MUL;
      ST_M_MUL: begin
        cmd_o.mul_go = 1'b1;
        state_d = ST_M_ACC;
      end
      ST_M_ACC: begin
        if (phase_q == PH_UPD) begin
          cmd_o.upd_go = 1'b1;
        end else begin
          cmd_o.acc_go    = 1'b1;
          cmd_o.acc_first = (p_q == 4'd0);
          cmd_o.acc_exact = (phase_q == PH_NB) || (phase_q == PH_NW);
        end
        p_d     = p_nx;
        state_d = (p_nx < n_q) ? ST_M_RD : ST_M_END;
      end
      ST_M_END: begin
        p_d     = '0;
        state_d = ST_M_RD;
        case (phase_q)
          PH_NB, PH_NW: begin
            cmd_o.sqrt_go = 1'b1;
            state_d = ST_SQ_WAIT;
          end
          PH_MV: begin
            cmd_o.w_ld = 1'b1;
            if (i_nx < n_q) begin
              i_d = i_nx;
            end else begin
              i_d     = '0;
              phase_d = PH_DOT;
            end
          end
          PH_DOT: begin
            cmd_o.hij_ld = 1'b1;
            cmd_o.h_we   = 1'b1;
            phase_d = PH_UPD;
          end
          PH_UPD: begin
            i_d     = i_nx;
            phase_d = ({1'b0, j_q} >= i_nx) ? PH_DOT : PH_NW;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SQ_WAIT: begin
        if (stat_i.sqrt_done) begin
          i_d = '0;
          if (phase_q == PH_NB) begin
            if (stat_i.nrm == '0) begin
              cmd_o.out_run = 1'b1;
              cmd_o.status  = RS_ZERO;
              cmd_o.steps   = '0;
              last_d  = '0;
              state_d = ST_IDLE;
            end else begin
              phase_d = PH_QB;
              state_d = ST_D_GO;
            end
          end else begin
            cmd_o.h_we    = 1'b1;
            cmd_o.h_wsel  = 1'b1;
            cmd_o.h_waddr = {j_nx, j_q};
            if ((stat_i.nrm < tol_q) || (stat_i.nrm == '0)) begin
              cmd_o.out_run = 1'b1;
              cmd_o.status  = RS_EARLY;
              cmd_o.steps   = j_nx;
              last_d  = j_nx;
              state_d = ST_IDLE;
            end else begin
              phase_d = PH_QW;
              state_d = ST_D_GO;
            end
          end
        end
      end
      ST_D_GO: begin
        cmd_o.vidx       = iix;
        cmd_o.div_go     = 1'b1;
        cmd_o.div_from_w = (phase_q == PH_QW);
        state_d = ST_D_WAIT;
      end
      ST_D_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.q_we = 1'b1;
          if (i_nx < n_q) begin
            i_d     = i_nx;
            state_d = ST_D_GO;
          end else begin
            i_d = '0;
            p_d = '0;
            if (phase_q == PH_QB) begin
              j_d = '0;
              if (k_q == '0) begin
                cmd_o.out_run = 1'b1;
                cmd_o.status  = RS_DONE;
                cmd_o.steps   = '0;
                last_d  = '0;
                state_d = ST_IDLE;
              end else begin
                phase_d = PH_MV;
                state_d = ST_M_RD;
              end
            end else begin
              j_d = j_nx;
              if (j_nx < k_q) begin
                phase_d = PH_MV;
                state_d = ST_M_RD;
              end else begin
                cmd_o.out_run = 1'b1;
                cmd_o.status  = RS_DONE;
                cmd_o.steps   = k_q;
                last_d  = k_q;
                state_d = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

>>> design/arnoldi_krylov_basis.sv
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid/s_axis_tready    command item: load, run or read
// m_axis    out  m_axis_tvalid/m_axis_tready    run result or read reply
// cfg       in   cfg_valid_i/cfg_ready_o        register index and write data
// a load is written on accept; a read reply passes states ST_RD_MEM and ST_RD_OUT
// a run steps each multiply through ST_M_RD, ST_M_MUL and ST_M_ACC on the single
// 32x32 multiplier, with ST_M_END at each loop end; the square root and the divide
// produce one bit a cycle
// reset clears control state only; the input waits while a result is held unread
module arnoldi_krylov_basis (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row_index, col_index, elem_value, zero pad
  input  logic [2:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // read_value, steps_done, zero pad
  output logic [1:0]  m_axis_tuser,  // run_status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import akb_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic signed [31:0] read_value;
  logic [2:0]         steps_done;

  akb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_row_i    (s_axis_tdata[2:0]),
    .in_col_i    (s_axis_tdata[5:3]),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  akb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .elem_value_i (s_axis_tdata[37:6]),
    .out_ready_i  (m_axis_tready),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .read_value_o (read_value),
    .run_status_o (m_axis_tuser),
    .steps_done_o (steps_done)
  );

  assign m_axis_tdata = {5'd0, steps_done, read_value};
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import akb_pkg::*;

  localparam int  QC        = K_MAX + 1;
  localparam int  CYC_LIMIT = 4000000;
  localparam logic [31:0] VMAX = 32'h7fff_ffff;
  localparam logic [31:0] VMIN = 32'h8000_0000;

  typedef struct {
    logic [31:0] read_value;
    logic [1:0]  run_status;
    logic [2:0]  steps_done;
  } reply_t;

  class arnoldi_scoreboard;
    logic signed [31:0] mat_a [N_MAX*N_MAX];
    logic signed [31:0] vec_b [N_MAX];
    logic signed [31:0] basis [N_MAX*QC];
    logic signed [31:0] hess [QC*K_MAX];
    logic signed [31:0] work [N_MAX];
    logic [1:0]  st_last;
    logic [2:0]  steps_last;
    logic [3:0]  dim;
    logic [2:0]  nsteps;
    logic [30:0] tol;
    reply_t      replies [$];
    int          errors, items, runs, reads;
    int          by_status [4];

    function new();
      foreach (mat_a[i]) mat_a[i] = 0;
      foreach (vec_b[i]) vec_b[i] = 0;
      foreach (basis[i]) basis[i] = 0;
      foreach (hess[i]) hess[i] = 0;
      foreach (work[i]) work[i] = 0;
      st_last = RS_DONE;
      steps_last = 0;
      dim = 8;
      nsteps = 7;
      tol = 1;
    endfunction

    function logic signed [31:0] sat(longint x);
      if (x > 64'sd2147483647) return VMAX;
      if (x < -64'sd2147483648) return VMIN;
      return x[31:0];
    endfunction

    function longint qmul(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b) + 32768;
      return p >>> 16;
    endfunction

    function logic signed [31:0] qdiv(logic signed [31:0] x, logic [31:0] d);
      longint unsigned mag, q;
      mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
      q = ((mag << 16) + longint'(d / 2)) / longint'(d);
      return sat((x < 0) ? -longint'(q) : longint'(q));
    endfunction

    function logic [31:0] norm_of(logic signed [31:0] v [N_MAX], int n);
      longint unsigned s, sq, r, b;
      s = 0;
      for (int i = 0; i < n; i++) begin
        sq = longint'(v[i]) * longint'(v[i]);
        if (s > 64'hffff_ffff_ffff_ffff - sq) s = 64'hffff_ffff_ffff_ffff;
        else s += sq;
      end
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return (r > 64'h7fff_ffff) ? VMAX : r[31:0];
    endfunction

    function void arnoldi_run();
      int n, k;
      logic [31:0] nb, h;
      longint acc;
      logic signed [31:0] hij;
      n = (dim < 1) ? 1 : (dim > N_MAX) ? N_MAX : dim;
      k = (nsteps > K_MAX) ? K_MAX : nsteps;
      if (k > n - 1) k = n - 1;
      foreach (basis[i]) basis[i] = 0;
      foreach (hess[i]) hess[i] = 0;
      nb = norm_of(vec_b, n);
      if (nb == 0) begin
        st_last = RS_ZERO;
        steps_last = 0;
        return;
      end
      for (int i = 0; i < n; i++) basis[i*QC] = qdiv(vec_b[i], nb);
      st_last = RS_DONE;
      steps_last = 3'(k);
      for (int j = 0; j < k; j++) begin
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int p = 0; p < n; p++) acc += qmul(mat_a[i*N_MAX+p], basis[p*QC+j]);
          work[i] = sat(acc);
        end
        for (int i = 0; i <= j; i++) begin
          acc = 0;
          for (int p = 0; p < n; p++) acc += qmul(basis[p*QC+i], work[p]);
          hij = sat(acc);
          hess[i*K_MAX+j] = hij;
          for (int p = 0; p < n; p++)
            work[p] = sat(longint'(work[p]) - qmul(hij, basis[p*QC+i]));
        end
        h = norm_of(work, n);
        hess[(j+1)*K_MAX+j] = h;
        if (h < {1'b0, tol} || h == 0) begin
          st_last = RS_EARLY;
          steps_last = 3'(j + 1);
          return;
        end
        for (int i = 0; i < n; i++) basis[i*QC+j+1] = qdiv(work[i], h);
      end
    endfunction

    function void note_config(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_SIZE:  dim = data[3:0];
        CFG_STEPS: nsteps = data[2:0];
        CFG_TOL:   tol = data[30:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] cmd, logic [2:0] row, logic [2:0] col,
                            logic [31:0] val);
      reply_t r;
      items++;
      r.read_value = 0;
      case (cmd)
        CMD_LOAD_A: begin
          mat_a[row*N_MAX+col] = val;
          return;
        end
        CMD_LOAD_B: begin
          vec_b[row] = val;
          return;
        end
        CMD_RUN: begin
          arnoldi_run();
          runs++;
          by_status[st_last]++;
          r.run_status = st_last;
        end
        CMD_READ_H: begin
          if (col < K_MAX) r.read_value = hess[row*K_MAX+col];
          r.run_status = RS_READ;
          reads++;
        end
        CMD_READ_Q: begin
          r.read_value = basis[row*QC+col];
          r.run_status = RS_READ;
          reads++;
        end
        default: return;
      endcase
      r.steps_done = steps_last;
      replies.push_back(r);
    endfunction

    function void check_result(logic [39:0] tdata, logic [1:0] tuser);
      reply_t r;
      if (replies.size() == 0) begin
        $error("unexpected result item: tdata %h tuser %0d", tdata, tuser);
        errors++;
        return;
      end
      r = replies.pop_front();
      if (tdata[31:0] !== r.read_value) begin
        $error("read_value expected %h got %h", r.read_value, tdata[31:0]);
        errors++;
      end
      if (tuser !== r.run_status) begin
        $error("run_status expected %0d got %0d", r.run_status, tuser);
        errors++;
      end
      if (tdata[34:32] !== r.steps_done) begin
        $error("steps_done expected %0d got %0d", r.steps_done, tdata[34:32]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  arnoldi_krylov_basis u_top (.*);

  arnoldi_scoreboard sb = new();
  int  cycles = 0;
  int  hold_req = 0;
  int  stall_left = 0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end else if (stall_left == 0 && $urandom_range(0, 9) < 2) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [2:0] row, logic [2:0] col,
                           logic [31:0] val);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, val, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(cmd, row, col, val);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.replies.size() != 0);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    if (r < 17) return $urandom();
    if (r == 17) return VMAX;
    if (r == 18) return VMIN;
    return 0;
  endfunction

  task automatic random_item();
    int r;
    logic [2:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 25) cmd = CMD_LOAD_A;
    else if (r < 37) cmd = CMD_LOAD_B;
    else if (r < 47) cmd = CMD_RUN;
    else if (r < 71) cmd = CMD_READ_H;
    else if (r < 95) cmd = CMD_READ_Q;
    else cmd = 3'($urandom_range(5, 7));
    send_item(cmd, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
              (cmd == CMD_LOAD_B && $urandom_range(0, 9) == 0) ? 32'h0 : rand_value());
  endtask

  initial begin
    logic [3:0]  sizes [8] = '{4'd1, 4'd2, 4'd8, 4'd4, 4'd15, 4'd0, 4'd5, 4'd8};
    logic [2:0]  ks [8]    = '{3'd1, 3'd1, 3'd7, 3'd3, 3'd0, 3'd7, 3'd2, 3'd7};
    logic [31:0] tols [8];
    tols = '{32'd1, 32'd0, 32'h7fff_ffff, 32'h0, 32'd1, 32'd0, 32'h0001_0000, 32'h8000_0001};
    tols[3] = $urandom_range(0, 1 << 20);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // every entry written before any run
    for (int r = 0; r < N_MAX; r++) begin
      for (int c = 0; c < N_MAX; c++) send_item(CMD_LOAD_A, 3'(r), 3'(c), rand_value());
      send_item(CMD_LOAD_B, 3'(r), 0, rand_value());
    end

    send_item(CMD_RUN, 0, 0, 0);
    send_item(CMD_READ_H, 0, 0, 0);
    send_item(CMD_READ_H, 7, 6, 0);
    send_item(CMD_READ_H, 7, 7, 0);
    send_item(CMD_READ_Q, 7, 7, 0);
    send_item(CMD_READ_Q, 0, 0, 0);
    for (int c = 5; c < 8; c++) send_item(3'(c), 3'd7, 3'd7, VMAX);
    for (int r = 0; r < N_MAX; r++) send_item(CMD_LOAD_B, 3'(r), 3'd7, 0);
    send_item(CMD_RUN, 0, 0, 0);
    send_item(CMD_READ_Q, 0, 0, 0);
    send_item(CMD_LOAD_B, 0, 0, VMAX);
    send_item(CMD_LOAD_B, 1, 0, VMIN);
    send_item(CMD_LOAD_A, 0, 0, VMAX);
    send_item(CMD_LOAD_A, 7, 7, VMIN);
    send_item(CMD_RUN, 0, 0, 0);
    send_item(CMD_READ_H, 1, 0, 0);
    send_item(CMD_READ_Q, 1, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SIZE, {28'h0, sizes[ph]});
      write_reg(CFG_STEPS, {29'h0, ks[ph]});
      write_reg(CFG_TOL, tols[ph]);
      cfg_valid_i <= 1'b0;
      if (ph == 2) begin
        hold_req = 600;
        for (int i = 0; i < 6; i++) begin
          send_item(CMD_READ_Q, 3'(i), 0, 0);
          send_item(CMD_RUN, 0, 0, 0);
        end
      end
      repeat (55) random_item();
      drain();
    end

    $display("%0d items driven: %0d runs (done %0d, early %0d, zero start %0d), %0d reads",
             sb.items, sb.runs, sb.by_status[RS_DONE], sb.by_status[RS_EARLY],
             sb.by_status[RS_ZERO], sb.reads);
    $display("eight register settings, sizes 0..15 and tolerance at both extremes");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
